@@ sv/sra_pkg.sv @@
`timescale 1ns / 1ps
package sra_pkg;

  localparam int ADDR_W      = 32;
  localparam int BYTES_W     = 24;
  localparam int SEG_BYTES_W = 16;
  localparam int FIRST_W     = 5;
  localparam int COUNT_W     = 6;
  localparam int RUN_BYTES_W = 25;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_RUN   = 2'd1,
    STAT_BAD_ADDR = 2'd2,
    STAT_NOT_INIT = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_BASE_ADDRESS  = 1'b0,
    CFG_SEGMENT_BYTES = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_ALLOC_MARK,
    ST_FREE_FIND,
    ST_FREE_TAG,
    ST_FREE_REL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic seg_used;
  } scan_ctrl_t;

  typedef struct packed {
    logic addr_hit;
    logic run_hit;
  } scan_stat_t;

endpackage

@@ sv/sra_marker_ram.sv @@
`timescale 1ns / 1ps
module sra_marker_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rd_valid_r <= valid_r[raddr];
    end
  end

  assign rdata = rd_valid_r ? rd_data_r : '0;

endmodule

@@ sv/sra_scan_unit.sv @@
`timescale 1ns / 1ps
module sra_scan_unit #(
  parameter int SEGMENTS = 32
) (
  input  logic                                clk,
  input  sra_pkg::scan_ctrl_t                 ctrl,
  input  logic [sra_pkg::SEG_BYTES_W-1:0]     seg_size,
  input  logic [sra_pkg::ADDR_W-1:0]          base,
  input  logic [sra_pkg::BYTES_W-1:0]         req_bytes,
  input  logic [sra_pkg::ADDR_W-1:0]          req_addr,
  output sra_pkg::scan_stat_t                 stat,
  output logic [$clog2(SEGMENTS+1)-1:0]       run_nxt,
  output logic [sra_pkg::ADDR_W-1:0]          run_addr
);

  localparam int CNT_W = $clog2(SEGMENTS + 1);

  logic [sra_pkg::ADDR_W-1:0]      addr_r;
  logic [sra_pkg::ADDR_W-1:0]      start_addr_r;
  logic [CNT_W-1:0]                run_r;
  logic [sra_pkg::RUN_BYTES_W-1:0] rb_r;
  logic [sra_pkg::RUN_BYTES_W-1:0] rb_sum;

  assign rb_sum        = rb_r + sra_pkg::RUN_BYTES_W'(seg_size);
  assign stat.addr_hit = (addr_r == req_addr);
  assign stat.run_hit  = !ctrl.seg_used &&
                         (rb_sum > sra_pkg::RUN_BYTES_W'(req_bytes));
  assign run_nxt       = ctrl.seg_used ? '0 : run_r + CNT_W'(1);
  assign run_addr      = (run_r == '0) ? addr_r : start_addr_r;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      addr_r       <= base;
      start_addr_r <= base;
      run_r        <= '0;
      rb_r         <= '0;
    end else if (ctrl.step) begin
      addr_r       <= addr_r + sra_pkg::ADDR_W'(seg_size);
      start_addr_r <= run_addr;
      run_r        <= run_nxt;
      rb_r         <= ctrl.seg_used ? '0 : rb_sum;
    end
  end

endmodule

@@ sv/segment_run_allocator.sv @@
`timescale 1ns / 1ps
// Channel   Ports                       Payload (low bit first)
// in        in_tvalid/in_tready         tdata: byte_count, address; tuser: mode
// out       out_tvalid/out_tready       tdata: block_address, first_segment,
//                                        segment_count; tuser: status
// cfg       cfg_valid/cfg_ready         cfg_index, cfg_data
//
// Init, unused mode and not-initialized requests pass through done to the output.
// Allocate: scans up to SEGMENTS segments, marks the granted ones, then done.
// Free: searches up to SEGMENTS segments, releases the tagged run, then done.
// The scan adder walks one segment per cycle; in_tready is high only when idle.
// Reset clears flags and the initialized flag, marker counter to 1; markers read 0.
// A waiting result is held in the output register while the next transfer is taken.
module segment_run_allocator #(
  parameter int SEGMENTS          = 32,
  parameter int MARKER_BITS       = 16,
  parameter int MIN_SEGMENT_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // byte_count[23:0], address[55:24]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // block_address[31:0], first_segment[36:32],
                                  // segment_count[42:37], zero[47:43]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = $clog2(SEGMENTS);
  localparam int CNT_W = $clog2(SEGMENTS + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SEGMENTS - 1);

  sra_pkg::state_t  state_r, state_nxt;
  sra_pkg::status_t res_status_r, res_status_nxt;
  sra_pkg::status_t out_status_r, out_status_nxt;

  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [IDX_W-1:0]       k_r, k_nxt;
  logic [IDX_W-1:0]       first_r, first_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [MARKER_BITS-1:0] tag_r, tag_nxt;
  logic [MARKER_BITS-1:0] next_marker_r, next_marker_nxt;
  logic [MARKER_BITS-1:0] marker_inc;
  logic [SEGMENTS-1:0]    used_r, used_nxt;
  logic                   ready_r, ready_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [31:0] res_addr_r, res_addr_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic [4:0]  out_first_r, out_first_nxt;
  logic [5:0]  out_count_r, out_count_nxt;
  logic [23:0] req_bytes_r, req_bytes_nxt;
  logic [31:0] req_addr_r, req_addr_nxt;
  logic [31:0] base_r;
  logic [15:0] seg_bytes_r;
  logic [15:0] seg_size;

  logic [CNT_W-1:0] start_w;
  logic [31:0]      first_ext;
  logic [31:0]      cnt_ext;

  sra_pkg::scan_ctrl_t scan_ctrl;
  sra_pkg::scan_stat_t scan_stat;
  logic [CNT_W-1:0]    run_nxt;
  logic [31:0]         run_addr;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [MARKER_BITS-1:0] ram_rdata;

  assign seg_size   = (seg_bytes_r == '0) ? 16'd1 : seg_bytes_r;
  assign in_tready  = (state_r == sra_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'd0, out_count_r, out_first_r, out_addr_r};
  assign marker_inc = next_marker_r + MARKER_BITS'(1);
  assign start_w    = CNT_W'(idx_r) + CNT_W'(1) - run_nxt;
  assign first_ext  = 32'(first_r);
  assign cnt_ext    = 32'(cnt_r);
  assign ram_raddr  = (state_r == sra_pkg::ST_FREE_FIND) ? idx_r : k_r + IDX_W'(1);

  sra_scan_unit #(
    .SEGMENTS (SEGMENTS)
  ) u_scan (
    .clk       (clk),
    .ctrl      (scan_ctrl),
    .seg_size  (seg_size),
    .base      (base_r),
    .req_bytes (req_bytes_r),
    .req_addr  (req_addr_r),
    .stat      (scan_stat),
    .run_nxt   (run_nxt),
    .run_addr  (run_addr)
  );

  sra_marker_ram #(
    .DEPTH (SEGMENTS),
    .WIDTH (MARKER_BITS)
  ) u_markers (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (k_r),
    .wdata (next_marker_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt          = state_r;
    res_status_nxt     = res_status_r;
    out_status_nxt     = out_status_r;
    idx_nxt            = idx_r;
    k_nxt              = k_r;
    first_nxt          = first_r;
    cnt_nxt            = cnt_r;
    tag_nxt            = tag_r;
    next_marker_nxt    = next_marker_r;
    used_nxt           = used_r;
    ready_nxt          = ready_r;
    out_valid_nxt      = out_valid_r;
    res_addr_nxt       = res_addr_r;
    out_addr_nxt       = out_addr_r;
    out_first_nxt      = out_first_r;
    out_count_nxt      = out_count_r;
    req_bytes_nxt      = req_bytes_r;
    req_addr_nxt       = req_addr_r;
    scan_ctrl.clear    = 1'b0;
    scan_ctrl.step     = 1'b0;
    scan_ctrl.seg_used = used_r[idx_r];
    ram_we             = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      sra_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          req_bytes_nxt   = in_tdata[23:0];
          req_addr_nxt    = in_tdata[55:24];
          idx_nxt         = '0;
          first_nxt       = '0;
          cnt_nxt         = '0;
          res_addr_nxt    = '0;
          res_status_nxt  = sra_pkg::STAT_OK;
          scan_ctrl.clear = 1'b1;
          state_nxt       = sra_pkg::ST_DONE;
          unique case (sra_pkg::mode_t'(in_tuser))
            sra_pkg::MODE_INIT: begin
              used_nxt        = '0;
              next_marker_nxt = MARKER_BITS'(1);
              ready_nxt       = 1'b1;
            end
            sra_pkg::MODE_RSVD: begin
            end
            sra_pkg::MODE_ALLOC: begin
              if (!ready_r) begin
                res_status_nxt = sra_pkg::STAT_NOT_INIT;
              end else begin
                state_nxt = sra_pkg::ST_ALLOC_SCAN;
              end
            end
            sra_pkg::MODE_FREE: begin
              if (!ready_r) begin
                res_status_nxt = sra_pkg::STAT_NOT_INIT;
              end else begin
                state_nxt = sra_pkg::ST_FREE_FIND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      sra_pkg::ST_ALLOC_SCAN: begin
        scan_ctrl.step = 1'b1;
        priority if (scan_stat.run_hit) begin
          k_nxt        = start_w[IDX_W-1:0];
          first_nxt    = start_w[IDX_W-1:0];
          cnt_nxt      = run_nxt;
          res_addr_nxt = run_addr;
          state_nxt    = sra_pkg::ST_ALLOC_MARK;
        end else if (idx_r == LAST) begin
          res_status_nxt = sra_pkg::STAT_NO_RUN;
          state_nxt      = sra_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      sra_pkg::ST_ALLOC_MARK: begin
        ram_we        = 1'b1;
        used_nxt[k_r] = 1'b1;
        if (k_r == idx_r) begin
          next_marker_nxt = (marker_inc == '0) ? MARKER_BITS'(1) : marker_inc;
          state_nxt       = sra_pkg::ST_DONE;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      sra_pkg::ST_FREE_FIND: begin
        scan_ctrl.step = 1'b1;
        priority if (scan_stat.addr_hit) begin
          k_nxt        = idx_r;
          first_nxt    = idx_r;
          res_addr_nxt = req_addr_r;
          state_nxt    = sra_pkg::ST_FREE_TAG;
        end else if (idx_r == LAST) begin
          res_status_nxt = sra_pkg::STAT_BAD_ADDR;
          state_nxt      = sra_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      sra_pkg::ST_FREE_TAG: begin
        tag_nxt       = ram_rdata;
        used_nxt[k_r] = 1'b0;
        cnt_nxt       = CNT_W'(1);
        if (k_r == LAST) begin
          state_nxt = sra_pkg::ST_DONE;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = sra_pkg::ST_FREE_REL;
        end
      end
      sra_pkg::ST_FREE_REL: begin
        if (ram_rdata == tag_r) begin
          used_nxt[k_r] = 1'b0;
          cnt_nxt       = cnt_r + CNT_W'(1);
          if (k_r == LAST) begin
            state_nxt = sra_pkg::ST_DONE;
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end else begin
          state_nxt = sra_pkg::ST_DONE;
        end
      end
      sra_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_first_nxt  = first_ext[4:0];
          out_count_nxt  = cnt_ext[5:0];
          state_nxt      = sra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sra_pkg::ST_IDLE;
      used_r        <= '0;
      next_marker_r <= MARKER_BITS'(1);
      ready_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      base_r        <= '0;
      seg_bytes_r   <= 16'(MIN_SEGMENT_BYTES);
    end else begin
      state_r       <= state_nxt;
      used_r        <= used_nxt;
      next_marker_r <= next_marker_nxt;
      ready_r       <= ready_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (sra_pkg::cfg_idx_t'(cfg_index))
          sra_pkg::CFG_BASE_ADDRESS:  base_r      <= cfg_data;
          sra_pkg::CFG_SEGMENT_BYTES: seg_bytes_r <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    first_r      <= first_nxt;
    cnt_r        <= cnt_nxt;
    tag_r        <= tag_nxt;
    res_addr_r   <= res_addr_nxt;
    out_addr_r   <= out_addr_nxt;
    out_first_r  <= out_first_nxt;
    out_count_r  <= out_count_nxt;
    req_bytes_r  <= req_bytes_nxt;
    req_addr_r   <= req_addr_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != sra_pkg::ST_IDLE)
    else $error("block idle right after an input transfer");

  a_mark_free_only: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sra_pkg::ST_ALLOC_MARK |-> !used_r[k_r])
    else $error("allocation marks a segment that is already used");

  a_marker_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_marker_r != '0)
    else $error("marker counter reached zero");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != sra_pkg::STAT_OK |-> out_tdata[31:0] == '0)
    else $error("failed request carries a nonzero address");

endmodule
